### design/ps2m_pkg.sv
`default_nettype none

package ps2m_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int LIMIT_W     = 12;
    localparam int FIELD_W     = 12;
    localparam int SUM_W       = (COORD_WIDTH + 2 > LIMIT_W + 2) ? COORD_WIDTH + 2 : LIMIT_W + 2;
    localparam int DATA_W      = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [COORD_WIDTH-1:0] POS_RESET   = COORD_WIDTH'(100);
    localparam logic [LIMIT_W-1:0]     X_LIMIT_RST = LIMIT_W'(1024);
    localparam logic [LIMIT_W-1:0]     Y_LIMIT_RST = LIMIT_W'(768);
    localparam logic [SUM_W-1:0]       COORD_MAX   = SUM_W'((1 << COORD_WIDTH) - 1);

    // header bit positions
    localparam int HB_LEFT  = 0;
    localparam int HB_RIGHT = 1;
    localparam int HB_SYNC  = 3;
    localparam int HB_XSIGN = 4;
    localparam int HB_YSIGN = 5;
    localparam int HB_XOVF  = 6;
    localparam int HB_YOVF  = 7;

    typedef enum logic [0:0] {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        BYTE_HEADER = 2'd0,
        BYTE_X      = 2'd1,
        BYTE_Y      = 2'd2
    } byte_slot_t;

    typedef enum logic [1:0] {
        ST_MOVED     = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_OFFSCREEN = 2'd2
    } upd_status_t;

    typedef struct packed {
        logic              last;
        logic [DATA_W-1:0] header;
        logic [DATA_W-1:0] x_byte;
        logic [DATA_W-1:0] y_byte;
    } packet_t;

    typedef struct packed {
        logic [FIELD_W-1:0] cursor_x;
        logic [FIELD_W-1:0] cursor_y;
        logic               left_button;
        logic               right_button;
        upd_status_t        update_status;
    } result_t;

endpackage

`default_nettype wire

### design/ps2m_align.sv
`default_nettype none

module ps2m_align (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [ps2m_pkg::DATA_W-1:0] data_byte,
    output ps2m_pkg::packet_t               pkt
);
    import ps2m_pkg::*;

    byte_slot_t        slot_reg;
    byte_slot_t        slot_next;
    logic [DATA_W-1:0] header_reg;
    logic [DATA_W-1:0] x_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= BYTE_HEADER;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && slot_reg != BYTE_X && slot_reg != BYTE_Y)
        begin
            header_reg <= data_byte;
        end
        if (accept && slot_reg == BYTE_X)
        begin
            x_byte_reg <= data_byte;
        end
    end

    // next state
    always_comb
    begin
        case (slot_reg)
            BYTE_X:  slot_next = BYTE_Y;
            BYTE_Y:  slot_next = BYTE_HEADER;
            default: slot_next = data_byte[HB_SYNC] ? BYTE_X : BYTE_HEADER;
        endcase
    end

    // outputs
    always_comb
    begin
        pkt.last   = (slot_reg == BYTE_Y);
        pkt.header = header_reg;
        pkt.x_byte = x_byte_reg;
        pkt.y_byte = data_byte;
    end

endmodule

`default_nettype wire

### design/ps2m_move.sv
`default_nettype none

module ps2m_move (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire ps2m_pkg::packet_t           pkt,
    input  wire logic [ps2m_pkg::LIMIT_W-1:0] x_limit,
    input  wire logic [ps2m_pkg::LIMIT_W-1:0] y_limit,
    output ps2m_pkg::result_t                res
);
    import ps2m_pkg::*;

    logic [COORD_WIDTH-1:0] pos_x_reg;
    logic [COORD_WIDTH-1:0] pos_y_reg;
    logic [COORD_WIDTH-1:0] pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_next;

    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;
    logic [SUM_W-1:0]        lim_x;
    logic [SUM_W-1:0]        lim_y;
    logic                    ovf;
    logic                    off;
    upd_status_t             status;

    always_comb
    begin
        // 9-bit deltas, sign from header
        dx = SUM_W'(signed'({pkt.header[HB_XSIGN], pkt.x_byte}));
        dy = SUM_W'(signed'({pkt.header[HB_YSIGN], pkt.y_byte}));
        nx = signed'(SUM_W'(pos_x_reg)) + dx;
        ny = signed'(SUM_W'(pos_y_reg)) - dy;

        lim_x = (SUM_W'(x_limit) > COORD_MAX) ? COORD_MAX : SUM_W'(x_limit);
        lim_y = (SUM_W'(y_limit) > COORD_MAX) ? COORD_MAX : SUM_W'(y_limit);

        ovf = pkt.header[HB_XOVF] | pkt.header[HB_YOVF];
        off = nx[SUM_W-1] || ny[SUM_W-1] || (unsigned'(nx) > lim_x) || (unsigned'(ny) > lim_y);

        if (ovf)
        begin
            status = ST_OVERFLOW;
        end
        else if (off)
        begin
            status = ST_OFFSCREEN;
        end
        else
        begin
            status = ST_MOVED;
        end

        if (status == ST_MOVED)
        begin
            pos_x_next = nx[COORD_WIDTH-1:0];
            pos_y_next = ny[COORD_WIDTH-1:0];
        end
        else
        begin
            pos_x_next = pos_x_reg;
            pos_y_next = pos_y_reg;
        end

        res.cursor_x      = FIELD_W'(pos_x_next);
        res.cursor_y      = FIELD_W'(pos_y_next);
        res.left_button   = pkt.header[HB_LEFT];
        res.right_button  = pkt.header[HB_RIGHT];
        res.update_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= POS_RESET;
            pos_y_reg <= POS_RESET;
        end
        else if (fire)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule

`default_nettype wire

### design/ps2_mouse_cursor_tracker.sv
`default_nettype none

// channel  | dir | signals                  | contents
// s_axis   | in  | s_tvalid/s_tready/s_tdata | one mouse byte a beat
// m_axis   | out | m_tvalid/m_tready/m_tdata | cursor result, one beat per packet
// cfg      | in  | cfg_we/cfg_index/cfg_wdata| x_limit (0), y_limit (1)
//
// one byte a cycle while s_tready is high; the third byte of a packet is decoded
// and the result lands in the output register on the edge that accepts it.
// header and x bytes are taken even while a result waits; the third byte waits
// only while the output register is full and not being drained.
// reset: position 100/100, limits 1024/768, packet alignment restarts.

module ps2_mouse_cursor_tracker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // data_byte[7:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // cursor_x[11:0], cursor_y[23:12], left_button[24], right_button[25],
    // update_status[27:26], zero[31:28]
    output logic [ps2m_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [ps2m_pkg::LIMIT_W-1:0]      cfg_wdata
);
    import ps2m_pkg::*;

    logic [LIMIT_W-1:0] x_limit_reg;
    logic [LIMIT_W-1:0] y_limit_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    packet_t            pkt;
    result_t            res;
    logic               accept;
    logic               fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_X_LIMIT: x_limit_reg <= cfg_wdata;
                REG_Y_LIMIT: y_limit_reg <= cfg_wdata;
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    assign s_tready = !pkt.last || !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign fire     = accept && pkt.last;

    ps2m_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .pkt       (pkt)
    );

    ps2m_move u_move (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .pkt     (pkt),
        .x_limit (x_limit_reg),
        .y_limit (y_limit_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.update_status, out_reg.right_button,
                       out_reg.left_button, out_reg.cursor_y, out_reg.cursor_x};

endmodule

`default_nettype wire

### tb/sv/ps2_mouse_cursor_tracker_tb.sv
`timescale 1ns / 100ps

module ps2_mouse_cursor_tracker_tb;

    import ps2m_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;     // data_byte[7:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // cursor_x[11:0], cursor_y[23:12], left_button[24], right_button[25],
    // update_status[27:26], zero[31:28]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wdata = '0;

    // tracker mirror
    byte_slot_t             slot = BYTE_HEADER;
    logic [7:0]             hdr_byte = 8'h00;
    logic [7:0]             dx_byte = 8'h00;
    logic [COORD_WIDTH-1:0] pos_x = POS_RESET;
    logic [COORD_WIDTH-1:0] pos_y = POS_RESET;
    logic [LIMIT_W-1:0]     x_lim = X_LIMIT_RST;
    logic [LIMIT_W-1:0]     y_lim = Y_LIMIT_RST;

    result_t                cursor_q[$];

    bit src_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int errors = 0;
    int bytes_sent = 0;
    int moves = 0;
    int overflows = 0;
    int offscreen = 0;
    int skipped = 0;
    int limit_writes = 0;

    ps2_mouse_cursor_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d cursor updates outstanding", cursor_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // consume one mouse byte and queue the cursor update it completes
    task automatic track_byte(input logic [7:0] b);
        result_t            r;
        upd_status_t        st;
        logic signed [13:0] dx, dy, nx, ny;
        case (slot)
            BYTE_X:
            begin
                dx_byte = b;
                slot = BYTE_Y;
            end
            BYTE_Y:
            begin
                slot = BYTE_HEADER;
                if (hdr_byte[HB_XOVF] || hdr_byte[HB_YOVF])
                begin
                    st = ST_OVERFLOW;
                    overflows++;
                end
                else
                begin
                    dx = {{6{hdr_byte[HB_XSIGN]}}, dx_byte};
                    dy = {{6{hdr_byte[HB_YSIGN]}}, b};
                    nx = $signed({2'b00, pos_x}) + dx;
                    ny = $signed({2'b00, pos_y}) - dy;
                    if (nx < 0 || nx > $signed({2'b00, x_lim}) ||
                        ny < 0 || ny > $signed({2'b00, y_lim}))
                    begin
                        st = ST_OFFSCREEN;
                        offscreen++;
                    end
                    else
                    begin
                        pos_x = nx[COORD_WIDTH-1:0];
                        pos_y = ny[COORD_WIDTH-1:0];
                        st = ST_MOVED;
                        moves++;
                    end
                end
                r.cursor_x      = pos_x;
                r.cursor_y      = pos_y;
                r.left_button   = hdr_byte[HB_LEFT];
                r.right_button  = hdr_byte[HB_RIGHT];
                r.update_status = st;
                cursor_q.push_back(r);
            end
            default:
            begin
                if (b[HB_SYNC])
                begin
                    hdr_byte = b;
                    slot = BYTE_X;
                end
                else
                begin
                    slot = BYTE_HEADER;
                    skipped++;
                end
            end
        endcase
    endtask

    // called and left at a falling edge; tvalid stays high for a following beat
    task automatic send_byte(input logic [7:0] b);
        int  gap;
        bit  taken;
        if (src_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(posedge clk);
            taken = s_tready;
            @(negedge clk);
        end
        while (!taken);
        bytes_sent++;
        track_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] h, input logic [7:0] xb,
                               input logic [7:0] yb);
        send_byte(h);
        send_byte(xb);
        send_byte(yb);
    endtask

    // let the last update drain before touching the limits
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cursor_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_limit(input reg_index_t idx, input logic [LIMIT_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_X_LIMIT)
            x_lim = v;
        else
            y_lim = v;
        limit_writes++;
    endtask

    // mostly short moves so the cursor wanders rather than hitting the edges
    function automatic logic [7:0] pick_delta(input logic neg);
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return neg ? 8'(256 - $urandom_range(1, 48)) : 8'($urandom_range(0, 48));
    endfunction

    task automatic send_random_item();
        int         kind;
        logic [7:0] h;
        kind = $urandom_range(0, 19);
        if (kind < 16)
        begin
            h = 8'($urandom);
            h[HB_SYNC] = 1'b1;
            h[HB_XOVF] = ($urandom_range(0, 15) == 0);
            h[HB_YOVF] = ($urandom_range(0, 15) == 0);
            send_packet(h, pick_delta(h[HB_XSIGN]), pick_delta(h[HB_YSIGN]));
        end
        else if (kind < 18)
            send_byte(8'($urandom));
        else
            send_byte(8'($urandom) & 8'hF7);
    endtask

    task automatic test_reset_values();
        send_packet(8'h09, 8'h00, 8'h00);   // no move, left held
        send_packet(8'h1A, 8'h9C, 8'h64);   // onto the origin, right held
        send_byte(8'h00);                    // out of sync, dropped
        send_byte(8'hF7);                    // every bit but sync, dropped
        send_packet(8'h48, 8'hFF, 8'hFF);   // x overflow
        send_packet(8'hCB, 8'h12, 8'h34);   // both overflow bits, buttons
        send_packet(8'h88, 8'h01, 8'h01);   // y overflow
        send_packet(8'h18, 8'hFF, 8'h00);   // left of the origin, rejected
        send_packet(8'h28, 8'hFF, 8'h00);   // largest +x, most negative y delta
    endtask

    task automatic test_limit_edges();
        write_limit(REG_X_LIMIT, 12'hFFF);
        write_limit(REG_Y_LIMIT, 12'hFFF);
        repeat (20) send_random_item();
        // park the limits on the cursor: still fits, one step more does not
        write_limit(REG_X_LIMIT, pos_x);
        write_limit(REG_Y_LIMIT, pos_y);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h08, 8'h01, 8'h00);
        send_packet(8'h28, 8'h00, 8'hFF);
        write_limit(REG_X_LIMIT, 12'h000);
        write_limit(REG_Y_LIMIT, 12'h000);
        repeat (10) send_random_item();
        write_limit(REG_X_LIMIT, X_LIMIT_RST);
        write_limit(REG_Y_LIMIT, Y_LIMIT_RST);
    endtask

    task automatic test_random_traffic();
        int start;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        for (int k = 0; k < 7; k++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                write_limit(REG_X_LIMIT, LIMIT_W'($urandom_range(pos_x, 4095)));
                write_limit(REG_Y_LIMIT, LIMIT_W'($urandom_range(pos_y, 4095)));
            end
            else
                write_limit(k[0] ? REG_Y_LIMIT : REG_X_LIMIT,
                            LIMIT_W'($urandom_range(0, 4095)));
            start = bytes_sent;
            // stall stretches come and go between chunks
            src_gaps    = (k != 2);
            sink_stalls = (k != 4);
            while (bytes_sent - start < 120)
                send_random_item();
        end
    endtask

    task automatic test_back_to_back();
        int start;
        settle();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < 160)
            send_random_item();
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cursor_q.size() == 0)
            begin
                $error("unexpected result beat, m_tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = cursor_q.pop_front();
                if (m_tdata[11:0] !== want.cursor_x)
                begin
                    $error("cursor_x: expected %0d, got %0d", want.cursor_x, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[23:12] !== want.cursor_y)
                begin
                    $error("cursor_y: expected %0d, got %0d", want.cursor_y, m_tdata[23:12]);
                    errors++;
                end
                if (m_tdata[24] !== want.left_button)
                begin
                    $error("left_button: expected %0d, got %0d", want.left_button, m_tdata[24]);
                    errors++;
                end
                if (m_tdata[25] !== want.right_button)
                begin
                    $error("right_button: expected %0d, got %0d",
                           want.right_button, m_tdata[25]);
                    errors++;
                end
                if (m_tdata[27:26] !== want.update_status)
                begin
                    $error("update_status: expected %0d, got %0d",
                           want.update_status, m_tdata[27:26]);
                    errors++;
                end
            end
        end
    end

    initial
    begin : sink_ready
        int n;
        forever
        begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_limit_edges();
        test_random_traffic();
        test_back_to_back();
        settle();
        repeat (10) @(negedge clk);
        $display("%0d mouse bytes sent: %0d moves, %0d overflow packets, %0d off-screen rejects",
                 bytes_sent, moves, overflows, offscreen);
        $display("%0d out-of-sync bytes skipped, %0d limit register writes",
                 skipped, limit_writes);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
